[rtl/brq_pkg.sv]
// Shared constants, codes and types of the broadcast ring queue.
package brq_pkg;

   localparam int DEPTH     = 64;
   localparam int READERS   = 8;
   localparam int WORD_BITS = 64;

   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int LEN_BITS  = $clog2(DEPTH + 1);
   localparam int RD_BITS   = (READERS > 1) ? $clog2(READERS) : 1;

   localparam int OP_W      = 2;
   localparam int READER_W  = 3;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 2;
   localparam int CFG_W     = 7;

   localparam logic [CFG_W-1:0] QLEN_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
   localparam logic [OP_W-1:0] OP_POP      = 2'd1;
   localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [READER_W-1:0]  reader;
      logic [PAYLOAD_W-1:0] push_word;
   } item_type;

   typedef struct packed {
      logic                wr_en;
      logic [PTR_BITS-1:0] wr_addr;
      logic                rd_en;
      logic [PTR_BITS-1:0] rd_addr;
   } ram_ctl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                pop_done;
   } result_type;

endpackage

[rtl/brq_if.sv]
// Channel interfaces of the broadcast ring queue: request, response, csr write.
interface brq_req_if;
   logic                           valid;
   logic                           ready;
   logic [brq_pkg::OP_W-1:0]       op;
   logic [brq_pkg::READER_W-1:0]   reader;
   logic [brq_pkg::PAYLOAD_W-1:0]  push_word;
   modport source (output valid, output op, output reader, output push_word, input ready);
   modport sink   (input valid, input op, input reader, input push_word, output ready);
endinterface

interface brq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [brq_pkg::STATUS_W-1:0]   status;
   logic [brq_pkg::PAYLOAD_W-1:0]  read_word;
   modport source (output valid, output status, output read_word, input ready);
   modport sink   (input valid, input status, input read_word, output ready);
endinterface

interface brq_csr_if;
   logic                        valid;
   logic                        ready;
   logic [brq_pkg::CFG_W-1:0]   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/broadcast_ring_queue_unit.sv]
// Top level of the broadcast ring queue: one writer, several readers on a ring.
//
//   channel  dir  fields                         handshake
//   req      in   op, reader, push_word          valid/ready
//   rsp      out  status, read_word              valid/ready
//   csr      in   data (queue length)            valid/ready, always ready
//
// One beat per cycle unless a held response stalls; its registered response shows
// in the cycle after accept, read_word from the slot RAM's registered read port.
// Reset clears pointers and reader flags; slot contents stay undefined, no sweep.
// req.ready drops only while a response is held by rsp.ready low.
module broadcast_ring_queue_unit (
   input logic        clock,
   input logic        reset,
   brq_req_if.sink    req,
   brq_rsp_if.source  rsp,
   brq_csr_if.sink    csr
);

   brq_pkg::item_type    item;
   brq_pkg::ram_ctl_type ram_ctl;
   brq_pkg::result_type  result;
   logic                 item_accept;
   logic                 cfg_wr;
   logic [brq_pkg::WORD_BITS-1:0] ram_rd_data;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [brq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         pop_ff, pop_in;

   assign item.op        = req.op;
   assign item.reader    = req.reader;
   assign item.push_word = req.push_word;

   assign req.ready   = !rsp_valid_ff || rsp.ready;
   assign item_accept = req.valid && req.ready;
   assign csr.ready   = 1'b1;
   assign cfg_wr      = csr.valid;

   brq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (item),
      .cfg_wr      (cfg_wr),
      .cfg_data    (csr.data),
      .ram_ctl     (ram_ctl),
      .result      (result)
   );

   brq_ram #(
      .WIDTH (brq_pkg::WORD_BITS),
      .DEPTH (brq_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (req.push_word[brq_pkg::WORD_BITS-1:0]),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      pop_in       = pop_ff;
      if (item_accept) begin
         rsp_valid_in = 1'b1;
         status_in    = result.status;
         pop_in       = result.pop_done;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      pop_ff    <= pop_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.read_word = pop_ff ? brq_pkg::PAYLOAD_W'(ram_rd_data) : '0;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      item_accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != brq_pkg::ST_DONE) |-> rsp.read_word == '0)
      else $error("read word nonzero on refused beat");

endmodule

[rtl/brq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module brq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/brq_ctrl.sv]
// Pointer state, reader flags and per-beat decision logic of the ring queue.
module brq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_accept,
   input  brq_pkg::item_type          item,
   input  logic                       cfg_wr,
   input  logic [brq_pkg::CFG_W-1:0]  cfg_data,
   output brq_pkg::ram_ctl_type       ram_ctl,
   output brq_pkg::result_type        result
);

   logic [brq_pkg::CFG_W-1:0]    qlen_ff, qlen_in;
   logic [brq_pkg::PTR_BITS-1:0] wp_ff, wp_in;
   logic [brq_pkg::PTR_BITS-1:0] rp_ff [brq_pkg::READERS];
   logic [brq_pkg::PTR_BITS-1:0] rp_in [brq_pkg::READERS];
   logic [brq_pkg::READERS-1:0]  act_ff, act_in;

   logic [brq_pkg::LEN_BITS-1:0] len;
   logic [brq_pkg::LEN_BITS-1:0] lag [brq_pkg::READERS];
   logic                         full;
   logic [brq_pkg::RD_BITS-1:0]  rsel;
   logic                         rvalid;

   function automatic logic [brq_pkg::PTR_BITS-1:0] ring_next(
      input logic [brq_pkg::PTR_BITS-1:0] p,
      input logic [brq_pkg::LEN_BITS-1:0] n_len
   );
      logic [brq_pkg::LEN_BITS-1:0] n;
      n = brq_pkg::LEN_BITS'(p) + brq_pkg::LEN_BITS'(1);
      return (n >= n_len) ? '0 : n[brq_pkg::PTR_BITS-1:0];
   endfunction

   always_comb begin
      if (qlen_ff < brq_pkg::CFG_W'(2)) begin
         len = brq_pkg::LEN_BITS'(2);
      end else if (brq_pkg::LEN_BITS'(qlen_ff) > brq_pkg::LEN_BITS'(brq_pkg::DEPTH)) begin
         len = brq_pkg::LEN_BITS'(brq_pkg::DEPTH);
      end else begin
         len = brq_pkg::LEN_BITS'(qlen_ff);
      end
   end

   // lag of every reader, compared in parallel for the full check
   always_comb begin
      full = 1'b0;
      for (int i = 0; i < brq_pkg::READERS; i++) begin
         if (rp_ff[i] <= wp_ff) begin
            lag[i] = brq_pkg::LEN_BITS'(wp_ff) - brq_pkg::LEN_BITS'(rp_ff[i]);
         end else begin
            lag[i] = len - brq_pkg::LEN_BITS'(rp_ff[i]) + brq_pkg::LEN_BITS'(wp_ff);
         end
         if (act_ff[i] && (lag[i] >= len - brq_pkg::LEN_BITS'(1))) begin
            full = 1'b1;
         end
      end
   end

   assign rsel   = item.reader[brq_pkg::RD_BITS-1:0];
   assign rvalid = int'(item.reader) < brq_pkg::READERS;

   always_comb begin
      qlen_in = qlen_ff;
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      act_in  = act_ff;
      ram_ctl.wr_en   = 1'b0;
      ram_ctl.wr_addr = wp_ff;
      ram_ctl.rd_en   = 1'b0;
      ram_ctl.rd_addr = rp_ff[rsel];
      result.status   = brq_pkg::ST_DONE;
      result.pop_done = 1'b0;
      case (item.op)
         brq_pkg::OP_PUSH: begin
            if (full) begin
               result.status = brq_pkg::ST_FULL;
            end else if (item_accept) begin
               ram_ctl.wr_en = 1'b1;
               wp_in = ring_next(wp_ff, len);
            end
         end
         brq_pkg::OP_POP: begin
            if (!rvalid || !act_ff[rsel]) begin
               result.status = brq_pkg::ST_INACTIVE;
            end else if (rp_ff[rsel] == wp_ff) begin
               result.status = brq_pkg::ST_EMPTY;
            end else begin
               result.pop_done = 1'b1;
               if (item_accept) begin
                  ram_ctl.rd_en = 1'b1;
                  rp_in[rsel] = ring_next(rp_ff[rsel], len);
               end
            end
         end
         brq_pkg::OP_ACTIVATE: begin
            if (!rvalid) begin
               result.status = brq_pkg::ST_INACTIVE;
            end else if (item_accept) begin
               act_in[rsel] = 1'b1;
               rp_in[rsel]  = wp_ff;
            end
         end
         default: begin
         end
      endcase
      if (cfg_wr) begin
         qlen_in = cfg_data;
         wp_in   = '0;
         for (int i = 0; i < brq_pkg::READERS; i++) begin
            rp_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff <= brq_pkg::QLEN_RESET;
         wp_ff   <= '0;
         act_ff  <= '0;
         for (int i = 0; i < brq_pkg::READERS; i++) begin
            rp_ff[i] <= '0;
         end
      end else begin
         qlen_ff <= qlen_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         act_ff  <= act_in;
      end
   end

   a_wp_in_ring: assert property (@(posedge clock) disable iff (reset)
      brq_pkg::LEN_BITS'(wp_ff) < len)
      else $error("write pointer beyond ring length");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (wp_ff == '0) && (rp_ff[0] == '0))
      else $error("length write did not empty the queue");

   a_push_moves: assert property (@(posedge clock) disable iff (reset)
      (item_accept && !cfg_wr && item.op == brq_pkg::OP_PUSH && !full) |=> wp_ff != $past(wp_ff))
      else $error("accepted push did not advance write pointer");

endmodule

[dv/tb_top.sv]
// Self-checking testbench of broadcast_ring_queue_unit: ring predictor, random traffic, stalls.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [brq_pkg::STATUS_W-1:0]  status;
      logic [brq_pkg::PAYLOAD_W-1:0] read_word;
   } ring_reply_type;

   localparam int IDLE_PCT   = 21;
   localparam int HOLD_BEATS = 60;
   localparam int QUIET_MAX  = 2000;

   localparam logic [brq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   brq_req_if req_if ();
   brq_rsp_if rsp_if ();
   brq_csr_if csr_if ();

   broadcast_ring_queue_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mirror of the ring state
   logic [brq_pkg::CFG_W-1:0]     ring_qlen;
   logic [brq_pkg::WORD_BITS-1:0] ring_slots [brq_pkg::DEPTH];
   logic [brq_pkg::PTR_BITS-1:0]  ring_wp;
   logic [brq_pkg::PTR_BITS-1:0]  ring_rp [brq_pkg::READERS];
   logic [brq_pkg::READERS-1:0]   ring_active;

   brq_pkg::item_type req_backlog [$];
   ring_reply_type    replies_owed [$];
   brq_pkg::item_type beat_on_bus;

   bit          idle_on = 1'b1;
   int unsigned hold_kicks = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet = 0;
   int unsigned mismatches = 0;

   int unsigned n_push = 0, n_full = 0, n_pop = 0, n_empty = 0;
   int unsigned n_inactive = 0, n_act = 0, n_other = 0, n_cfg = 0, n_rsp = 0;

   function automatic int unsigned ring_len();
      if (ring_qlen < 2) return 2;
      if (ring_qlen > brq_pkg::DEPTH) return brq_pkg::DEPTH;
      return ring_qlen;
   endfunction

   function automatic int unsigned next_ptr(int unsigned p, int unsigned len);
      return (p + 1 >= len) ? 0 : p + 1;
   endfunction

   function automatic int unsigned words_waiting(int unsigned r, int unsigned len);
      int unsigned w;
      w = ring_wp;
      return (r <= w) ? w - r : len - r + w;
   endfunction

   function automatic ring_reply_type ring_respond(brq_pkg::item_type it);
      ring_reply_type rep;
      int unsigned    len;
      int unsigned    r;
      logic           full;
      len = ring_len();
      rep.status = brq_pkg::ST_DONE;
      rep.read_word = '0;
      full = 1'b0;
      if (ring_wp >= len) ring_wp = '0;
      case (it.op)
         brq_pkg::OP_PUSH: begin
            for (int i = 0; i < brq_pkg::READERS; i++)
               if (ring_active[i] && words_waiting(ring_rp[i], len) >= len - 1) full = 1'b1;
            if (full) begin
               rep.status = brq_pkg::ST_FULL;
               n_full++;
            end else begin
               ring_slots[ring_wp] = it.push_word[brq_pkg::WORD_BITS-1:0];
               ring_wp = brq_pkg::PTR_BITS'(next_ptr(ring_wp, len));
               n_push++;
            end
         end
         brq_pkg::OP_POP: begin
            if (it.reader >= brq_pkg::READERS || !ring_active[it.reader]) begin
               rep.status = brq_pkg::ST_INACTIVE;
               n_inactive++;
            end else begin
               r = ring_rp[it.reader];
               if (words_waiting(r, len) == 0) begin
                  rep.status = brq_pkg::ST_EMPTY;
                  n_empty++;
               end else begin
                  rep.read_word = ring_slots[r];
                  ring_rp[it.reader] = brq_pkg::PTR_BITS'(next_ptr(r, len));
                  n_pop++;
               end
            end
         end
         brq_pkg::OP_ACTIVATE: begin
            if (it.reader >= brq_pkg::READERS) begin
               rep.status = brq_pkg::ST_INACTIVE;
               n_inactive++;
            end else begin
               ring_active[it.reader] = 1'b1;
               ring_rp[it.reader] = ring_wp;
               n_act++;
            end
         end
         default: n_other++;
      endcase
      return rep;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid)
            replies_owed.push_back(ring_respond(beat_on_bus));
         if (req_backlog.size() > 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
            beat_on_bus = req_backlog.pop_front();
            req_if.valid     <= 1'b1;
            req_if.op        <= beat_on_bus.op;
            req_if.reader    <= beat_on_bus.reader;
            req_if.push_word <= beat_on_bus.push_word;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      ring_reply_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            n_rsp++;
            if (replies_owed.size() == 0) begin
               mismatches++;
               $error("unexpected beat: status %0d read_word %h",
                      rsp_if.status, rsp_if.read_word);
            end else begin
               want = replies_owed.pop_front();
               if (rsp_if.status !== want.status) begin
                  mismatches++;
                  $error("status: expected %0d actual %0d", want.status, rsp_if.status);
               end
               if (rsp_if.read_word !== want.read_word) begin
                  mismatches++;
                  $error("read_word: expected %h actual %h", want.read_word, rsp_if.read_word);
               end
            end
         end
         if (hold_kicks != hold_served) begin
            hold_served = hold_kicks;
            hold_left = HOLD_BEATS;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_MAX) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic queue_beat(logic [brq_pkg::OP_W-1:0] op, logic [brq_pkg::READER_W-1:0] rd,
                             logic [brq_pkg::PAYLOAD_W-1:0] word);
      brq_pkg::item_type it;
      it.op = op;
      it.reader = rd;
      it.push_word = word;
      req_backlog.push_back(it);
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_if.valid || replies_owed.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_queue_length(logic [brq_pkg::CFG_W-1:0] len_value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= len_value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      ring_qlen = len_value;
      ring_wp = '0;
      foreach (ring_rp[i]) ring_rp[i] = '0;
      n_cfg++;
   endtask

   function automatic logic [brq_pkg::PAYLOAD_W-1:0] random_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [brq_pkg::READER_W-1:0] random_reader();
      return brq_pkg::READER_W'($urandom_range(7));
   endfunction

   task automatic random_phase(int unsigned beats, int unsigned push_pct);
      int unsigned roll;
      for (int k = 0; k < beats; k++) begin
         roll = $urandom_range(99);
         if (roll < 3)
            queue_beat(OP_UNUSED, random_reader(), random_word());
         else if (roll < 8)
            queue_beat(brq_pkg::OP_ACTIVATE, random_reader(), random_word());
         else if (roll < 8 + push_pct)
            queue_beat(brq_pkg::OP_PUSH, random_reader(), random_word());
         else
            queue_beat(brq_pkg::OP_POP, random_reader(), random_word());
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.op = brq_pkg::OP_PUSH;
      req_if.reader = '0;
      req_if.push_word = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      ring_qlen = brq_pkg::QLEN_RESET;
      ring_wp = '0;
      foreach (ring_rp[i]) ring_rp[i] = '0;
      ring_active = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset length: inactive pop, push with no reader, unused op, reactivation
      queue_beat(brq_pkg::OP_POP, 3'd0, '0);
      queue_beat(brq_pkg::OP_PUSH, 3'd2, 64'h0123_4567_89ab_cdef);
      queue_beat(OP_UNUSED, 3'd7, '1);
      queue_beat(brq_pkg::OP_ACTIVATE, 3'd7, '0);
      queue_beat(brq_pkg::OP_POP, 3'd7, '0);
      queue_beat(brq_pkg::OP_PUSH, 3'd0, '1);
      queue_beat(brq_pkg::OP_PUSH, 3'd7, '0);
      queue_beat(brq_pkg::OP_POP, 3'd7, '0);
      queue_beat(brq_pkg::OP_POP, 3'd7, '1);
      queue_beat(brq_pkg::OP_POP, 3'd7, '0);
      queue_beat(brq_pkg::OP_ACTIVATE, 3'd7, '1);
      settle();

      // short ring: full refusal, wrap, drain to empty
      set_queue_length(7'd3);
      queue_beat(brq_pkg::OP_ACTIVATE, 3'd0, '0);
      queue_beat(brq_pkg::OP_PUSH, 3'd0, 64'haaaa_aaaa_aaaa_aaaa);
      queue_beat(brq_pkg::OP_PUSH, 3'd0, 64'h5555_5555_5555_5555);
      queue_beat(brq_pkg::OP_PUSH, 3'd0, 64'h8000_0000_0000_0001);
      queue_beat(brq_pkg::OP_POP, 3'd0, '0);
      queue_beat(brq_pkg::OP_PUSH, 3'd0, 64'h8000_0000_0000_0001);
      queue_beat(brq_pkg::OP_POP, 3'd7, '0);
      queue_beat(brq_pkg::OP_PUSH, 3'd0, 64'h8000_0000_0000_0001);
      queue_beat(brq_pkg::OP_POP, 3'd0, '0);
      queue_beat(brq_pkg::OP_POP, 3'd0, '0);
      queue_beat(brq_pkg::OP_POP, 3'd0, '0);
      queue_beat(brq_pkg::OP_POP, 3'd5, '0);
      settle();

      set_queue_length(7'd0);
      random_phase(60, 45);
      settle();
      set_queue_length(7'd1);
      random_phase(60, 45);
      settle();
      set_queue_length(7'd2);
      random_phase(60, 40);
      settle();

      // deep ring, push heavy, with a long receiver hold-off to back up the input
      set_queue_length(7'd127);
      random_phase(100, 72);
      hold_kicks++;
      settle();

      idle_on = 1'b0;
      set_queue_length(7'd64);
      random_phase(100, 55);
      settle();
      idle_on = 1'b1;

      set_queue_length(7'd65);
      random_phase(60, 30);
      settle();
      repeat (3) begin
         set_queue_length(brq_pkg::CFG_W'($urandom_range(16, 2)));
         random_phase(50, 50);
         settle();
      end
      set_queue_length(7'd5);
      random_phase(60, 50);
      settle();
      repeat (10) @(posedge clock);

      $display("Run covered %0d beats: %0d pushes stored, %0d refused full, %0d words popped",
               n_rsp, n_push, n_full, n_pop);
      $display("  %0d empty, %0d inactive, %0d activations, %0d unused op, %0d length writes",
               n_empty, n_inactive, n_act, n_other, n_cfg);
      if (mismatches == 0 && replies_owed.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
